/* design/hpt_pkg.sv */
// Shared constants and helpers for the homogeneous point transform.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

  localparam int FIELD_W         = 32;  // width of every coordinate field
  localparam int MAT_W           = 32;  // width of one matrix entry
  localparam int CFG_W           = 64;  // widest configuration register
  localparam int CFG_IDX_W       = 4;   // index port, wide enough to see stray writes
  localparam int NUM_REGS        = 8;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COORD_WIDTH = 32;

  // Width of the full-precision sum of three products plus translation.
  function automatic int sum_width(input int cw, input int f);
    int m;
    begin
      m = (cw > f) ? cw : f;
      return m + MAT_W + 2;
    end
  endfunction

  // Width of one transformed component after dropping the extra fraction bits.
  function automatic int comp_width(input int cw, input int f);
    begin
      return sum_width(cw, f) - f;
    end
  endfunction

endpackage
`default_nettype wire

/* design/hpt_ifs.sv */
// Handshake channels for points in and transformed results out.
// Depends on hpt_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none
interface hpt_point_if;
  import hpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] in_x;
  logic [FIELD_W-1:0] in_y;
  logic [FIELD_W-1:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hpt_result_if;
  import hpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] out_x;
  logic [FIELD_W-1:0] out_y;
  logic [FIELD_W-1:0] out_z;
  logic               w_zero;
  logic               saturated;
  modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface
`default_nettype wire

/* design/hpt_mac.sv */
// Matrix multiply: product stage then sum-and-reduce stage, two registers deep.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpt_mac #(
  parameter int FRAC_BITS   = hpt_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = hpt_pkg::DEF_COORD_WIDTH
) (
  input  logic clk,
  input  logic en,
  input  logic [COORD_WIDTH-1:0] px,
  input  logic [COORD_WIDTH-1:0] py,
  input  logic [COORD_WIDTH-1:0] pz,
  input  logic [3:0][3:0][hpt_pkg::MAT_W-1:0] mat,
  output logic [3:0][hpt_pkg::comp_width(COORD_WIDTH, FRAC_BITS)-1:0] comp
);
  import hpt_pkg::*;

  localparam int PW     = COORD_WIDTH + MAT_W;
  localparam int SW     = sum_width(COORD_WIDTH, FRAC_BITS);
  localparam int COMP_W = comp_width(COORD_WIDTH, FRAC_BITS);

  logic [3:0][2:0][PW-1:0] prod;
  logic [3:0][2:0][PW-1:0] prod_next;
  logic [3:0][COMP_W-1:0]  comp_next;
  logic [2:0][COORD_WIDTH-1:0] p;

  assign p = {pz, py, px};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_next[j][i] = PW'(signed'(p[i]) * signed'(mat[i][j]));
      end
    end
  end

  // Floor of the exact sum: arithmetic shift after adding everything.
  always_comb begin
    logic signed [SW-1:0] s;
    for (int j = 0; j < 4; j++) begin
      s = SW'(signed'(prod[j][0])) + SW'(signed'(prod[j][1])) + SW'(signed'(prod[j][2]))
        + (SW'(signed'(mat[3][j])) <<< FRAC_BITS);
      comp_next[j] = COMP_W'(s >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      comp <= comp_next;
    end
  end

endmodule
`default_nettype wire

/* design/hpt_div_step.sv */
// One restoring-division step for the three lanes, one quotient bit each.
// Depends on hpt_pkg only by convention; all widths come from parameters.
`timescale 1ns / 1ps
`default_nettype none
module hpt_div_step #(
  parameter int DW  = 51,
  parameter int NW  = 67,
  parameter int QW  = 33,
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic en,
  input  logic [DW-1:0]        d_in,
  input  logic [2:0][DW-1:0]   rem_in,
  input  logic [2:0][NW-1:0]   n_in,
  input  logic [2:0][QW-1:0]   q_in,
  output logic [DW-1:0]        d_out,
  output logic [2:0][DW-1:0]   rem_out,
  output logic [2:0][NW-1:0]   n_out,
  output logic [2:0][QW-1:0]   q_out
);
  import hpt_pkg::*;

  logic [2:0][DW-1:0] rem_next;
  logic [2:0]         qbit;

  always_comb begin
    logic [DW:0] t;
    for (int l = 0; l < 3; l++) begin
      t       = {rem_in[l], n_in[l][BIT]};
      qbit[l] = (t >= {1'b0, d_in});
      rem_next[l] = qbit[l] ? DW'(t - {1'b0, d_in}) : DW'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_in;
      n_out <= n_in;
      for (int l = 0; l < 3; l++) begin
        rem_out[l] <= rem_next[l];
        q_out[l]   <= {q_in[l][QW-2:0], qbit[l]};
      end
    end
  end

endmodule
`default_nettype wire

/* design/homogeneous_point_transform_unit.sv */
// Top level of the homogeneous point transform: matrix registers, pipeline control.
// Depends on hpt_pkg, hpt_ifs, hpt_mac and hpt_div_step.
`timescale 1ns / 1ps
`default_nettype none
// Transforms one point (x, y, z, 1) by a 4x4 Q-format matrix and divides x, y, z
// by w, truncating toward zero. One request is taken every clock while the output
// register is empty or being read. Stages: input register, product stage,
// sum stage, divide set-up stage, COORD_WIDTH + 1 quotient-bit stages of the
// pipelined restoring divider, and the output register. The divider chain sets
// the depth. All stages advance together whenever the output register is empty
// or being read, so a stalled result holds the whole pipe and nothing is lost.
// Matrix registers come out of reset as identity and should be written only
// while the pipe is empty. w of exactly one bypasses the divide (clamp only);
// w of zero gives zero outputs with w_zero set.
module homogeneous_point_transform_unit #(
  parameter int FRAC_BITS   = hpt_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = hpt_pkg::DEF_COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic                          cfg_we,
  input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpt_pkg::CFG_W-1:0]     cfg_data,
  hpt_point_if.sink                     points,
  hpt_result_if.source                  results
);
  import hpt_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int COMP_W = comp_width(CW, FRAC_BITS);
  localparam int DW     = COMP_W;              // divisor magnitude
  localparam int NW     = COMP_W + FRAC_BITS;  // scaled dividend
  localparam int QW     = CW + 1;              // quotient bits kept

  typedef struct packed {
    logic [2:0][COMP_W-1:0] c;
    logic                   w_zero;
    logic                   w_one;
    logic [2:0]             neg;
    logic [2:0]             ovf;
  } side_t;

  localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_BITS;
  localparam logic [COMP_W-1:0] CMAX = {{(COMP_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [COMP_W-1:0] CMIN = {{(COMP_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [QW-1:0]     QPOS = {2'b00, {(CW-1){1'b1}}};
  localparam logic [QW-1:0]     QNEG = {2'b01, {(CW-1){1'b0}}};

  // Matrix registers
  logic [3:0][3:0][MAT_W-1:0] mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= (r == c) ? (MAT_W'(1) << FRAC_BITS) : '0;
        end
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      mat[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[MAT_W-1:0];
      mat[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[2*MAT_W-1:MAT_W];
    end
  end

  // Pipeline control: every stage moves together
  logic adv;
  logic v_a, v_b, v_c, v_d;
  logic [QW-1:0] v_div;

  assign adv          = !results.valid || results.ready;
  assign points.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a           <= 1'b0;
      v_b           <= 1'b0;
      v_c           <= 1'b0;
      v_d           <= 1'b0;
      v_div         <= '0;
      results.valid <= 1'b0;
    end else if (adv) begin
      v_a           <= points.valid;
      v_b           <= v_a;
      v_c           <= v_b;
      v_d           <= v_c;
      v_div         <= {v_div[QW-2:0], v_d};
      results.valid <= v_div[QW-1];
    end
  end

  // Input register
  logic [CW-1:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= points.in_x[CW-1:0];
      py <= points.in_y[CW-1:0];
      pz <= points.in_z[CW-1:0];
    end
  end

  // Products and sums (two stages)
  logic [3:0][COMP_W-1:0] comp;

  hpt_mac #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (CW)
  ) u_mac (
    .clk  (clk),
    .en   (adv),
    .px   (px),
    .py   (py),
    .pz   (pz),
    .mat  (mat),
    .comp (comp)
  );

  // Divide set-up: magnitudes, signs, special w, early overflow
  logic [QW:0][DW-1:0]        d_pipe;
  logic [QW:0][2:0][DW-1:0]   rem_pipe;
  logic [QW:0][2:0][NW-1:0]   n_pipe;
  logic [QW:0][2:0][QW-1:0]   q_pipe;
  side_t [QW:0]               side_pipe;

  side_t                side_next;
  logic [DW-1:0]        d_next;
  logic [2:0][DW-1:0]   rem_next;
  logic [2:0][NW-1:0]   n_next;

  logic [DW-1:0]        d_s0;
  logic [2:0][DW-1:0]   rem_s0;
  logic [2:0][NW-1:0]   n_s0;

  always_comb begin
    logic [DW-1:0] un;
    d_next           = comp[3][COMP_W-1] ? DW'(-comp[3]) : comp[3];
    side_next.w_zero = (comp[3] == '0);
    side_next.w_one  = (comp[3] == ONE);
    for (int l = 0; l < 3; l++) begin
      un                = comp[l][COMP_W-1] ? DW'(-comp[l]) : comp[l];
      n_next[l]         = {un, {FRAC_BITS{1'b0}}};
      side_next.c[l]    = comp[l];
      side_next.neg[l]  = comp[l][COMP_W-1] ^ comp[3][COMP_W-1];
      // quotient would need more than QW bits
      side_next.ovf[l]  = ((n_next[l] >> QW) >= NW'(d_next));
      rem_next[l]       = DW'(n_next[l] >> QW);
    end
  end

  // side data shifts along with the divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      d_s0      <= d_next;
      rem_s0    <= rem_next;
      n_s0      <= n_next;
      side_pipe <= {side_pipe[QW-1:0], side_next};
    end
  end

  assign d_pipe[0]   = d_s0;
  assign rem_pipe[0] = rem_s0;
  assign n_pipe[0]   = n_s0;
  assign q_pipe[0]   = '0;

  // Quotient-bit stages, most significant bit first
  for (genvar s = 0; s < QW; s++) begin : g_div
    hpt_div_step #(
      .DW  (DW),
      .NW  (NW),
      .QW  (QW),
      .BIT (QW - 1 - s)
    ) u_step (
      .clk     (clk),
      .en      (adv),
      .d_in    (d_pipe[s]),
      .rem_in  (rem_pipe[s]),
      .n_in    (n_pipe[s]),
      .q_in    (q_pipe[s]),
      .d_out   (d_pipe[s+1]),
      .rem_out (rem_pipe[s+1]),
      .n_out   (n_pipe[s+1]),
      .q_out   (q_pipe[s+1])
    );
  end

  // Sign, clamp and special-case selection into the output register
  side_t                 fin;
  logic [2:0][CW-1:0]    res_val;
  logic [2:0]            res_sat;

  assign fin = side_pipe[QW];

  always_comb begin
    logic [QW-1:0] q;
    for (int l = 0; l < 3; l++) begin
      q = q_pipe[QW][l];
      if (fin.w_one) begin
        // pass-through with clamp
        if (signed'(fin.c[l]) > signed'(CMAX)) begin
          res_val[l] = CMAX[CW-1:0];
          res_sat[l] = 1'b1;
        end else if (signed'(fin.c[l]) < signed'(CMIN)) begin
          res_val[l] = CMIN[CW-1:0];
          res_sat[l] = 1'b1;
        end else begin
          res_val[l] = fin.c[l][CW-1:0];
          res_sat[l] = 1'b0;
        end
      end else if (fin.neg[l]) begin
        if (fin.ovf[l] || (q > QNEG)) begin
          res_val[l] = CMIN[CW-1:0];
          res_sat[l] = 1'b1;
        end else begin
          res_val[l] = CW'(-q);
          res_sat[l] = 1'b0;
        end
      end else begin
        if (fin.ovf[l] || (q > QPOS)) begin
          res_val[l] = CMAX[CW-1:0];
          res_sat[l] = 1'b1;
        end else begin
          res_val[l] = q[CW-1:0];
          res_sat[l] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.w_zero) begin
        results.out_x     <= '0;
        results.out_y     <= '0;
        results.out_z     <= '0;
        results.w_zero    <= 1'b1;
        results.saturated <= 1'b0;
      end else begin
        results.out_x     <= FIELD_W'(signed'(res_val[0]));
        results.out_y     <= FIELD_W'(signed'(res_val[1]));
        results.out_z     <= FIELD_W'(signed'(res_val[2]));
        results.w_zero    <= 1'b0;
        results.saturated <= |res_sat;
      end
    end
  end

endmodule
`default_nettype wire
